// ===== hdl/dvru_pkg.sv =====
package dvru_pkg;

    // Fixed field widths
    localparam int DIST_W  = 30;
    localparam int HOP_W   = 5;
    localparam int FIELD_W = 4;
    localparam int OP_W    = 2;

    // Distance that marks an unreachable destination, and the empty next hop
    localparam logic [DIST_W-1:0] UNREACH = 30'd1000000000;
    localparam logic [HOP_W-1:0]  NO_HOP  = 5'd16;

    // Opcodes
    localparam logic [OP_W-1:0] OP_INIT = 2'd0;
    localparam logic [OP_W-1:0] OP_ADV  = 2'd1;
    localparam logic [OP_W-1:0] OP_END  = 2'd2;
    localparam logic [OP_W-1:0] OP_READ = 2'd3;

    // Write request from the update logic to the route tables
    typedef struct packed {
        logic              dist_we;
        logic              link_we;
        logic [DIST_W-1:0] dist_val;
        logic [HOP_W-1:0]  hop;
        logic [DIST_W-1:0] link;
    } tbl_wr_t;

endpackage

// ===== hdl/distance_vector_route_update.sv =====
// Channel   Direction  Ports                                         Handshake
// s_        in         s_opcode s_dest_index s_neighbor s_value      s_valid/s_ready
// m_        out        m_distance m_next_hop m_entry_updated
//                      m_any_update                                  m_valid/m_ready
// cfg_      in         cfg_wr_data (self_id)                         cfg_wr_en
//
// For each item, the transfer cycle issues the table reads; the compute step then
// computes, writes back and loads the output register.
// The registered reads of the route and link memories set this split.
// A result held in the output register does not block the next transfer; only the
// compute cycle waits until the output register is free.
// Reset (aresetn low, synchronous) clears valid bits, flags and self_id; no sweep.
module distance_vector_route_update #(
    parameter int MAX_ROUTERS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [dvru_pkg::FIELD_W-1:0]  cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [dvru_pkg::OP_W-1:0]     s_opcode,
    input  logic [dvru_pkg::FIELD_W-1:0]  s_dest_index,
    input  logic [dvru_pkg::FIELD_W-1:0]  s_neighbor,
    input  logic [dvru_pkg::DIST_W-1:0]   s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [dvru_pkg::DIST_W-1:0]   m_distance,
    output logic [dvru_pkg::HOP_W-1:0]    m_next_hop,
    output logic                          m_entry_updated,
    output logic                          m_any_update
);
    import dvru_pkg::*;

    localparam int IDX_W = $clog2(MAX_ROUTERS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;

    logic [FIELD_W-1:0]  self_id_reg;
    logic [OP_W-1:0]     op_reg;
    logic [FIELD_W-1:0]  dest_reg;
    logic [FIELD_W-1:0]  nb_reg;
    logic [DIST_W-1:0]   val_reg;

    logic [MAX_ROUTERS-1:0] pending_reg, pending_next;
    logic [MAX_ROUTERS-1:0] round_reg, round_next;

    logic                m_valid_reg;
    logic [DIST_W-1:0]   m_dist_reg, m_dist_next;
    logic [HOP_W-1:0]    m_hop_reg, m_hop_next;
    logic                m_upd_reg, m_upd_next;
    logic                m_any_reg, m_any_next;

    logic                s_fire, exec_fire;
    logic                dest_ok, nb_ok, self_ok;
    logic [IDX_W-1:0]    dest_addr, self_addr, rd_dest, rd_nb, wr_addr;
    logic [DIST_W-1:0]   cur_dist, cur_link;
    logic [HOP_W-1:0]    cur_hop;
    logic [DIST_W:0]     cand;
    logic                relax;
    tbl_wr_t             wr;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign exec_fire = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);

    // Table reads use the incoming item's indices
    assign rd_dest = IDX_W'(s_dest_index);
    assign rd_nb   = IDX_W'(s_neighbor);

    // Range checks and addresses of the item at work
    assign dest_ok   = 32'(dest_reg) < MAX_ROUTERS;
    assign nb_ok     = 32'(nb_reg) < MAX_ROUTERS;
    assign self_ok   = 32'(self_id_reg) < MAX_ROUTERS;
    assign dest_addr = IDX_W'(dest_reg);
    assign self_addr = IDX_W'(self_id_reg);

    dvru_table #(
        .DEPTH (MAX_ROUTERS)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_fire),
        .rd_dest (rd_dest),
        .rd_nb   (rd_nb),
        .wr_addr (wr_addr),
        .wr      (wr),
        .rd_dist (cur_dist),
        .rd_hop  (cur_hop),
        .rd_link (cur_link)
    );

    // Relaxation candidate
    assign cand  = {1'b0, cur_link} + {1'b0, val_reg};
    assign relax = dest_ok && nb_ok && (val_reg < UNREACH) && (cand < {1'b0, cur_dist});

    assign wr_addr = (op_reg == OP_END) ? self_addr : dest_addr;

    // Compute the write-back, flags and result of the item at work
    always_comb begin
        wr           = '0;
        pending_next = pending_reg;
        round_next   = round_reg;
        m_dist_next  = UNREACH;
        m_hop_next   = NO_HOP;
        m_upd_next   = 1'b0;
        m_any_next   = 1'b0;
        unique case (op_reg)
            OP_INIT: begin
                if (dest_ok) begin
                    wr.dist_we = exec_fire;
                    wr.link_we = exec_fire;
                    if (val_reg >= UNREACH) begin
                        wr.dist_val = UNREACH;
                        wr.hop      = NO_HOP;
                    end else begin
                        wr.dist_val = val_reg;
                        wr.hop      = {1'b0, dest_reg};
                    end
                    wr.link     = wr.dist_val;
                    m_dist_next = wr.dist_val;
                    m_hop_next  = wr.hop;
                end
            end
            OP_ADV: begin
                if (relax) begin
                    wr.dist_we  = exec_fire;
                    wr.dist_val = cand[DIST_W-1:0];
                    wr.hop      = {1'b0, nb_reg};
                    pending_next[dest_addr] = 1'b1;
                    m_dist_next = wr.dist_val;
                    m_hop_next  = wr.hop;
                    m_upd_next  = 1'b1;
                end else if (dest_ok) begin
                    m_dist_next = cur_dist;
                    m_hop_next  = cur_hop;
                end
            end
            OP_END: begin
                round_next   = pending_reg;
                pending_next = '0;
                m_any_next   = |pending_reg;
                if (self_ok) begin
                    wr.dist_we  = exec_fire;
                    wr.dist_val = '0;
                    wr.hop      = {1'b0, self_id_reg};
                    m_dist_next = '0;
                    m_hop_next  = wr.hop;
                    m_upd_next  = pending_reg[self_addr];
                end
            end
            OP_READ: begin
                if (dest_ok) begin
                    m_dist_next = cur_dist;
                    m_hop_next  = cur_hop;
                    m_upd_next  = round_reg[dest_addr];
                end
            end
            default: begin
                wr = '0;
            end
        endcase
    end

    // Sequence: accept, then compute once the output register is free
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_fire) state_next = ST_EXEC;
            ST_EXEC: if (exec_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            self_id_reg <= '0;
            pending_reg <= '0;
            round_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                self_id_reg <= cfg_wr_data;
            end
            if (exec_fire) begin
                pending_reg <= pending_next;
                round_reg   <= round_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the item on transfer; load the result on commit
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg   <= s_opcode;
            dest_reg <= s_dest_index;
            nb_reg   <= s_neighbor;
            val_reg  <= s_value;
        end
        if (exec_fire) begin
            m_dist_reg <= m_dist_next;
            m_hop_reg  <= m_hop_next;
            m_upd_reg  <= m_upd_next;
            m_any_reg  <= m_any_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_distance      = m_dist_reg;
    assign m_next_hop      = m_hop_reg;
    assign m_entry_updated = m_upd_reg;
    assign m_any_update    = m_any_reg;

    // The compute cycle never overlaps a transfer
    a_no_accept_in_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) |-> !s_ready)
        else $error("input accepted while an item is at work");

    // An end of round leaves no pending flag behind
    a_end_clears_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_fire && op_reg == OP_END) |=> (pending_reg == '0))
        else $error("pending flags survive end of round");

    // Every committed item yields a result
    a_commit_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire |=> m_valid)
        else $error("committed item produced no result");

    // Next hop is a router index or none
    a_hop_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_next_hop <= NO_HOP))
        else $error("next hop out of range");

endmodule

// ===== hdl/dvru_table.sv =====
module dvru_table #(
    parameter int DEPTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH)-1:0]     rd_dest,
    input  logic [$clog2(DEPTH)-1:0]     rd_nb,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  dvru_pkg::tbl_wr_t            wr,
    output logic [dvru_pkg::DIST_W-1:0]  rd_dist,
    output logic [dvru_pkg::HOP_W-1:0]   rd_hop,
    output logic [dvru_pkg::DIST_W-1:0]  rd_link
);
    import dvru_pkg::*;

    // Route memory holds distance and next hop; link memory holds link costs
    logic [DIST_W+HOP_W-1:0] route_mem [DEPTH];
    logic [DIST_W-1:0]       link_mem  [DEPTH];

    // Entries never written read as unreachable
    logic [DEPTH-1:0] route_vld_reg;
    logic [DEPTH-1:0] link_vld_reg;

    logic [DIST_W+HOP_W-1:0] route_q_reg;
    logic [DIST_W-1:0]       link_q_reg;
    logic                    route_vq_reg;
    logic                    link_vq_reg;

    // Synchronous read ports, registered on rd_en
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            route_q_reg <= route_mem[rd_dest];
            link_q_reg  <= link_mem[rd_nb];
        end
        if (wr.dist_we) begin
            route_mem[wr_addr] <= {wr.dist_val, wr.hop};
        end
        if (wr.link_we) begin
            link_mem[wr_addr] <= wr.link;
        end
    end

    // Valid bits and their read copies
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            route_vld_reg <= '0;
            link_vld_reg  <= '0;
            route_vq_reg  <= 1'b0;
            link_vq_reg   <= 1'b0;
        end else begin
            if (rd_en) begin
                route_vq_reg <= route_vld_reg[rd_dest];
                link_vq_reg  <= link_vld_reg[rd_nb];
            end
            if (wr.dist_we) begin
                route_vld_reg[wr_addr] <= 1'b1;
            end
            if (wr.link_we) begin
                link_vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Substitute reset values for unwritten entries
    assign rd_dist = route_vq_reg ? route_q_reg[DIST_W+HOP_W-1:HOP_W] : UNREACH;
    assign rd_hop  = route_vq_reg ? route_q_reg[HOP_W-1:0] : NO_HOP;
    assign rd_link = link_vq_reg ? link_q_reg : UNREACH;

endmodule
